// ----- hw/rtl/wpt_pkg.sv -----
package wpt_pkg;

  // operation codes carried on in_func
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POOL_EMPTY = 2'd1,
    ST_NONE_ACT   = 2'd2,
    ST_NOT_ACT    = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned IDX_PORT_W = 5;

endpackage

// ----- hw/rtl/watchpoint_pool_table.sv -----
// Watchpoint pool with a LIFO free list. busy is high in the cycle after start
// is taken, and the result is on the out_ ports in the cycle after that,
// marked by out_valid; start may be high again in that same cycle, so a new
// item can be taken while the last result is presented, but not while busy.
// This follows from the registered reads of the entry and free-list memories:
// the issue cycle issues the read, the execute cycle does the modify and write
// back. The receiver cannot stall; every result is presented exactly once. No
// clearing pass follows reset: entry valid marks and free-list slot marks are
// flip-flops cleared at once, so the block can take an item as soon as reset
// is released.
module watchpoint_pool_table #(
  parameter int unsigned NUM_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_watch_addr,
  input  logic [63:0] in_mem_value,
  input  logic [4:0]  in_watch_index,
  // result side
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [4:0]  out_entry_index,
  output logic        out_changed,
  output logic        out_entry_active
);

  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_ENTRIES + 1);

  // ---------------------------------------------------------------------
  // storage
  // ---------------------------------------------------------------------
  // entry payload memories, contents undefined until an allocate writes them
  logic [wpt_pkg::DATA_W-1:0] addr_mem [NUM_ENTRIES];
  logic [wpt_pkg::DATA_W-1:0] old_mem  [NUM_ENTRIES];
  // free-list memory, not reset; slot_written_r marks the slots that were pushed
  logic [IDX_W-1:0]           stack_mem [NUM_ENTRIES];

  logic [NUM_ENTRIES-1:0] entry_valid_r;   // entry is allocated
  logic [NUM_ENTRIES-1:0] slot_written_r;  // free-list slot has been pushed
  logic [CNT_W-1:0]       free_count_r;

  // ---------------------------------------------------------------------
  // sequencer and latched command
  // ---------------------------------------------------------------------
  wpt_pkg::state_t state_r, state_nxt;

  wpt_pkg::op_t                func_r;
  logic [wpt_pkg::DATA_W-1:0]  addr_r;
  logic [wpt_pkg::DATA_W-1:0]  mval_r;
  logic [4:0]                  widx_r;
  logic [IDX_W-1:0]            slot_r;     // free-list top slot at issue time

  logic [wpt_pkg::DATA_W-1:0]  old_q;      // registered read of old_mem
  logic [IDX_W-1:0]            stack_q;    // registered read of stack_mem

  logic             accept;
  logic [IDX_W-1:0] top_slot;
  logic [IDX_W-1:0] widx_in_mem;

  assign busy   = (state_r == wpt_pkg::S_EXEC);
  assign accept = start && !busy;

  // top of free list is slot free_count-1; park at slot 0 when empty
  always_comb begin
    if (free_count_r == '0) begin
      top_slot = '0;
    end else begin
      top_slot = IDX_W'(free_count_r - CNT_W'(1));
    end
  end

  assign widx_in_mem = IDX_W'(in_watch_index);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wpt_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = wpt_pkg::S_EXEC;
        end
      end
      wpt_pkg::S_EXEC: begin
        state_nxt = wpt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = wpt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wpt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command latch, no reset needed on payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= wpt_pkg::op_t'(in_func);
      addr_r <= in_watch_addr;
      mval_r <= in_mem_value;
      widx_r <= in_watch_index;
      slot_r <= top_slot;
    end
  end

  // ---------------------------------------------------------------------
  // execute cycle: decode with the read data in hand
  // ---------------------------------------------------------------------
  logic             widx_in_range;
  logic [IDX_W-1:0] widx_e;
  logic [IDX_W-1:0] alloc_entry;
  logic             widx_active;

  assign widx_in_range = (32'(widx_r) < NUM_ENTRIES);
  assign widx_e        = IDX_W'(widx_r);
  assign widx_active   = widx_in_range && entry_valid_r[widx_e];

  // unwritten slot s holds NUM_ENTRIES-1-s
  assign alloc_entry = slot_written_r[slot_r] ? stack_q
                     : IDX_W'(NUM_ENTRIES - 1) - slot_r;

  logic                 do_alloc;
  logic                 do_free;
  wpt_pkg::status_t     status_nxt;
  logic [4:0]           index_nxt;
  logic                 changed_nxt;
  logic                 active_nxt;

  always_comb begin
    do_alloc    = 1'b0;
    do_free     = 1'b0;
    status_nxt  = wpt_pkg::ST_OK;
    index_nxt   = '0;
    changed_nxt = 1'b0;
    active_nxt  = 1'b0;
    case (func_r)
      wpt_pkg::OP_ALLOC: begin
        if (free_count_r == '0) begin
          status_nxt = wpt_pkg::ST_POOL_EMPTY;
        end else begin
          do_alloc   = 1'b1;
          index_nxt  = 5'(alloc_entry);
          active_nxt = 1'b1;
        end
      end
      wpt_pkg::OP_FREE: begin
        index_nxt = widx_r;
        if (32'(free_count_r) >= NUM_ENTRIES) begin
          status_nxt = wpt_pkg::ST_NONE_ACT;
        end else if (!widx_active) begin
          status_nxt = wpt_pkg::ST_NOT_ACT;
        end else begin
          do_free = 1'b1;
        end
      end
      wpt_pkg::OP_CHECK: begin
        index_nxt = widx_r;
        if (widx_active) begin
          active_nxt  = 1'b1;
          changed_nxt = (mval_r != old_q);
        end
      end
      default: begin
        // unused code: all-zero result
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // memories: read at issue, write back in execute
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      old_q <= old_mem[widx_in_mem];
    end
    if (busy && do_alloc) begin
      old_mem[alloc_entry] <= mval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && do_alloc) begin
      addr_mem[alloc_entry] <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stack_q <= stack_mem[top_slot];
    end
    if (busy && do_free) begin
      stack_mem[IDX_W'(free_count_r)] <= widx_e;
    end
  end

  // valid marks, slot marks and free count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r  <= '0;
      slot_written_r <= '0;
      free_count_r   <= CNT_W'(NUM_ENTRIES);
    end else if (busy) begin
      if (do_alloc) begin
        entry_valid_r[alloc_entry] <= 1'b1;
        free_count_r               <= free_count_r - CNT_W'(1);
      end
      if (do_free) begin
        entry_valid_r[widx_e]                   <= 1'b0;
        slot_written_r[IDX_W'(free_count_r)]    <= 1'b1;
        free_count_r                            <= free_count_r + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // result register: one strobe per item
  // ---------------------------------------------------------------------
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [4:0] out_index_r;
  logic       out_changed_r;
  logic       out_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_status_r  <= status_nxt;
      out_index_r   <= index_nxt;
      out_changed_r <= changed_nxt;
      out_active_r  <= active_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_index  = out_index_r;
  assign out_changed      = out_changed_r;
  assign out_entry_active = out_active_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("execute state held longer than one cycle");

  a_result_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("no result after execute cycle");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_valid)
    else $error("result without a transfer in execute");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_count_r) <= NUM_ENTRIES)
    else $error("free count above pool size");

  a_changed_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_changed |-> out_entry_active)
    else $error("stop request on an inactive entry");

endmodule
